[hw/rtl/mdct_pkg.sv]
// ----------------------------------------------------------------------------
// mdct_pkg
// Shared types and codes for the minimum distance cell table.
// ----------------------------------------------------------------------------
package mdct_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef logic [AW-1:0] slot_t;
	typedef logic [CW-1:0] count_t;
	typedef logic [15:0] coord_t;
	typedef logic [31:0] dist_t;

	// operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_BAD   = 2'd3;

	localparam dist_t DIST_NONE = '1;

	// one table slot as held in memory
	typedef struct packed {
		logic   valid;
		logic   pend;
		coord_t row;
		coord_t column;
		dist_t  distance;
	} entry_t;

endpackage

[hw/rtl/mdct_req_if.sv]
// ----------------------------------------------------------------------------
// mdct_req_if
// Request channel of the cell table: operation and cell fields.
// ----------------------------------------------------------------------------
interface mdct_req_if;
	import mdct_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	slot_t       slot;
	coord_t      row;
	coord_t      column;
	dist_t       dist_req;

	modport source (output valid, opcode, slot, row, column, dist_req, input ready);
	modport sink   (input valid, opcode, slot, row, column, dist_req, output ready);
endinterface

[hw/rtl/mdct_rsp_if.sv]
// ----------------------------------------------------------------------------
// mdct_rsp_if
// Response channel of the cell table: status, cell and table totals.
// ----------------------------------------------------------------------------
interface mdct_rsp_if;
	import mdct_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  status;
	slot_t       out_slot;
	coord_t      out_row;
	coord_t      out_column;
	dist_t       out_dist;
	dist_t       min_dist;
	count_t      cell_count;

	modport source (output valid, status, out_slot, out_row, out_column, out_dist,
		min_dist, cell_count, input ready);
	modport sink   (input valid, status, out_slot, out_row, out_column, out_dist,
		min_dist, cell_count, output ready);
endinterface

[hw/rtl/min_distance_cell_table_top.sv]
// ----------------------------------------------------------------------------
// min_distance_cell_table_top
// Table of distance cells with add, remove, clear and get-smallest.
// ----------------------------------------------------------------------------
// Usage
//   req carries one operation per request: add a cell, remove a slot, get the
//   smallest cell or clear the table. rsp returns exactly one response per
//   request, in order, with status, the cell touched and the table totals.
//   All slots live in one single-port-write, registered-read memory; every
//   operation is a read-modify-write sequence over it, one request at a time.
// Latency (cycles from acceptance to response loaded)
//   add: lowest free slot search, up to TABLE_DEPTH + 3
//   remove: 3; clear: TABLE_DEPTH + 1
//   get smallest with ties pending: downward search, up to TABLE_DEPTH + 3
//   get smallest with no ties: minimum pass plus marking pass,
//   about 2 * TABLE_DEPTH + 5
//   The sweep through the memory, one slot per cycle, sets these figures.
// Reset
//   after arst_n the table runs a clearing pass of TABLE_DEPTH cycles with
//   req.ready low.
// Stalls
//   a response held by rsp.ready low stays in the output register; the next
//   request is still taken and worked on, and waits only to be loaded.
// ----------------------------------------------------------------------------
module min_distance_cell_table_top (
	input  logic       clk,
	input  logic       arst_n,
	mdct_req_if.sink   req,
	mdct_rsp_if.source rsp
);
	import mdct_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLEAR  = 3'd1;
	localparam logic [2:0] S_ADD    = 3'd2;
	localparam logic [2:0] S_REM_RD = 3'd3;
	localparam logic [2:0] S_REM_CK = 3'd4;
	localparam logic [2:0] S_MIN    = 3'd5;
	localparam logic [2:0] S_MARK   = 3'd6;
	localparam logic [2:0] S_PEND   = 3'd7;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_data_s1;

	logic [2:0] state_q;
	logic       resp_wait_q;
	logic       reply_q;
	count_t     cnt_q;
	logic       vld_s1;
	slot_t      addr_s1;

	slot_t      slot_q;
	coord_t     row_q;
	coord_t     column_q;
	dist_t      dist_q;

	count_t     valid_total_q;
	count_t     pend_total_q;
	dist_t      run_min_q;
	dist_t      best_q;
	logic       seen_q;
	logic       got_q;

	logic [1:0] res_status_q;
	slot_t      res_slot_q;
	coord_t     res_row_q;
	coord_t     res_column_q;
	dist_t      res_dist_q;

	logic       out_valid_q;
	logic [1:0] out_status_q;
	slot_t      out_slot_q;
	coord_t     out_row_q;
	coord_t     out_column_q;
	dist_t      out_dist_q;
	dist_t      out_min_q;
	count_t     out_count_q;

	logic       scanning;
	logic       down;
	logic       iss;
	slot_t      iss_addr;
	count_t     down_cnt;
	logic       scan_end;
	logic       we;
	slot_t      wa;
	entry_t     wd;
	logic       hit_add;
	logic       hit_mark;
	logic       hit_pend;

	// read issue for the sweeps and the remove read
	always_comb begin
		scanning = (state_q == S_ADD) || (state_q == S_MIN) ||
			(state_q == S_MARK) || (state_q == S_PEND);
		down     = (state_q == S_MARK) || (state_q == S_PEND);
		down_cnt = count_t'(TABLE_DEPTH - 1) - cnt_q;
		iss      = (scanning && (cnt_q < count_t'(TABLE_DEPTH))) || (state_q == S_REM_RD);
		if (state_q == S_REM_RD) begin
			iss_addr = slot_q;
		end else if (down) begin
			iss_addr = down_cnt[AW-1:0];
		end else begin
			iss_addr = cnt_q[AW-1:0];
		end
		scan_end = !iss && !vld_s1;
	end

	// match tests on the returned entry
	always_comb begin
		hit_add  = (state_q == S_ADD) && vld_s1 && !rd_data_s1.valid;
		hit_mark = (state_q == S_MARK) && vld_s1 && rd_data_s1.valid &&
			(rd_data_s1.distance == best_q);
		hit_pend = (state_q == S_PEND) && vld_s1 && rd_data_s1.pend;
	end

	// write back
	always_comb begin
		we = 1'b0;
		wa = addr_s1;
		wd = rd_data_s1;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = cnt_q[AW-1:0];
				wd = '0;
			end
			S_ADD: begin
				we = hit_add;
				wd = '{valid: 1'b1, pend: 1'b0, row: row_q, column: column_q,
					distance: dist_q};
			end
			S_REM_CK: begin
				we = rd_data_s1.valid;
				wd.valid = 1'b0;
				wd.pend  = 1'b0;
			end
			S_MARK: begin
				we = hit_mark && got_q;
				wd.pend = 1'b1;
			end
			S_PEND: begin
				we = hit_pend;
				wd.pend = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_s1 <= mem[iss_addr];
		addr_s1    <= iss_addr;
	end

	assign req.ready = (state_q == S_IDLE) && !resp_wait_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			resp_wait_q   <= 1'b0;
			reply_q       <= 1'b0;
			cnt_q         <= '0;
			vld_s1        <= 1'b0;
			valid_total_q <= '0;
			pend_total_q  <= '0;
			run_min_q     <= DIST_NONE;
			seen_q        <= 1'b0;
			got_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			vld_s1 <= iss;
			if (iss || state_q == S_CLEAR) begin
				cnt_q <= cnt_q + count_t'(1);
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (resp_wait_q) begin
						// response waits for the output register
						if (!out_valid_q || rsp.ready) begin
							out_valid_q  <= 1'b1;
							out_status_q <= res_status_q;
							out_slot_q   <= res_slot_q;
							out_row_q    <= res_row_q;
							out_column_q <= res_column_q;
							out_dist_q   <= res_dist_q;
							out_min_q    <= run_min_q;
							out_count_q  <= valid_total_q;
							resp_wait_q  <= 1'b0;
						end
					end else if (req.valid) begin
						slot_q       <= req.slot;
						row_q        <= req.row;
						column_q     <= req.column;
						dist_q       <= req.dist_req;
						res_status_q <= STAT_OK;
						res_slot_q   <= '0;
						res_row_q    <= '0;
						res_column_q <= '0;
						res_dist_q   <= '0;
						cnt_q        <= '0;
						seen_q       <= 1'b0;
						got_q        <= 1'b0;
						case (req.opcode)
							OP_ADD: begin
								if (valid_total_q >= count_t'(TABLE_DEPTH)) begin
									res_status_q <= STAT_FULL;
									resp_wait_q  <= 1'b1;
								end else begin
									state_q <= S_ADD;
								end
							end
							OP_REMOVE: begin
								if ({1'b0, req.slot} >= (AW + 1)'(TABLE_DEPTH)) begin
									res_status_q <= STAT_BAD;
									resp_wait_q  <= 1'b1;
								end else begin
									state_q <= S_REM_RD;
								end
							end
							OP_GET: begin
								if (pend_total_q != '0) begin
									state_q <= S_PEND;
								end else if (valid_total_q == '0) begin
									res_status_q <= STAT_EMPTY;
									resp_wait_q  <= 1'b1;
								end else begin
									state_q <= S_MIN;
								end
							end
							OP_CLEAR: begin
								reply_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CLEAR: begin
					// one slot a cycle; the totals are cleared with the last slot
					if (cnt_q == count_t'(TABLE_DEPTH - 1)) begin
						valid_total_q <= '0;
						pend_total_q  <= '0;
						run_min_q     <= DIST_NONE;
						resp_wait_q   <= reply_q;
						reply_q       <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				S_ADD: begin
					if (hit_add) begin
						valid_total_q <= valid_total_q + count_t'(1);
						if (dist_q < run_min_q) begin
							run_min_q <= dist_q;
						end
						res_slot_q  <= addr_s1;
						resp_wait_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (scan_end) begin
						res_status_q <= STAT_FULL;
						resp_wait_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_REM_RD: begin
					state_q <= S_REM_CK;
				end
				S_REM_CK: begin
					if (rd_data_s1.valid) begin
						valid_total_q <= valid_total_q - count_t'(1);
						if (rd_data_s1.pend && pend_total_q != '0) begin
							pend_total_q <= pend_total_q - count_t'(1);
						end
						res_slot_q <= slot_q;
					end else begin
						res_status_q <= STAT_BAD;
					end
					resp_wait_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_MIN: begin
					// smallest distance over valid slots
					if (vld_s1 && rd_data_s1.valid &&
						(!seen_q || rd_data_s1.distance < best_q)) begin
						best_q <= rd_data_s1.distance;
						seen_q <= 1'b1;
					end
					if (scan_end) begin
						run_min_q <= best_q;
						cnt_q     <= '0;
						state_q   <= S_MARK;
					end
				end
				S_MARK: begin
					// highest tie is handed out, the rest are marked
					if (hit_mark) begin
						if (!got_q) begin
							got_q        <= 1'b1;
							res_slot_q   <= addr_s1;
							res_row_q    <= rd_data_s1.row;
							res_column_q <= rd_data_s1.column;
							res_dist_q   <= rd_data_s1.distance;
						end else begin
							pend_total_q <= pend_total_q + count_t'(1);
						end
					end
					if (scan_end) begin
						if (!got_q) begin
							res_status_q <= STAT_EMPTY;
						end
						resp_wait_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_PEND: begin
					// highest pending tie
					if (hit_pend) begin
						pend_total_q <= pend_total_q - count_t'(1);
						res_slot_q   <= addr_s1;
						res_row_q    <= rd_data_s1.row;
						res_column_q <= rd_data_s1.column;
						res_dist_q   <= rd_data_s1.distance;
						resp_wait_q  <= 1'b1;
						state_q      <= S_IDLE;
					end else if (scan_end) begin
						pend_total_q <= '0;
						res_status_q <= STAT_EMPTY;
						resp_wait_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.out_slot   = out_slot_q;
	assign rsp.out_row    = out_row_q;
	assign rsp.out_column = out_column_q;
	assign rsp.out_dist   = out_dist_q;
	assign rsp.min_dist   = out_min_q;
	assign rsp.cell_count = out_count_q;

endmodule

[hw/rtl/mdct_chk.sv]
// ----------------------------------------------------------------------------
// mdct_chk
// Port-level checks of the cell table, bound to the top level.
// ----------------------------------------------------------------------------
module mdct_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [1:0]           status,
	input mdct_pkg::coord_t     out_row,
	input mdct_pkg::coord_t     out_column,
	input mdct_pkg::dist_t      out_dist,
	input mdct_pkg::count_t     cell_count
);
	import mdct_pkg::*;

	// a stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("response dropped while stalled");

	// full is only reported on a full table
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_FULL |-> cell_count == count_t'(TABLE_DEPTH))
		else $error("full reported below capacity");

	// count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cell_count <= count_t'(TABLE_DEPTH))
		else $error("cell count beyond capacity");

	// failed requests carry no cell
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |->
		out_row == '0 && out_column == '0 && out_dist == '0)
		else $error("cell fields set on a failed request");

endmodule

bind min_distance_cell_table_top mdct_chk u_mdct_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.out_row    (rsp.out_row),
	.out_column (rsp.out_column),
	.out_dist   (rsp.out_dist),
	.cell_count (rsp.cell_count)
);
